/* hdl/pei_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pei_pkg
// Shared types, register indexes and saturation helpers of the particle
// Euler integrator.
// ----------------------------------------------------------------------------
package pei_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int QUEUE_AW    = 3;

	localparam logic [1:0] REG_TIME_STEP = 2'd0;
	localparam logic [1:0] REG_FRICTION  = 2'd1;
	localparam logic [1:0] REG_MAX_SPEED = 2'd2;

	localparam logic [19:0] TIME_STEP_RST = 20'd1092;
	localparam logic [15:0] FRICTION_RST  = 16'd0;
	localparam logic [30:0] MAX_SPEED_RST = 31'd655360;

	typedef logic [2:0][31:0] vec3_t;

	// one particle between the front and the back
	typedef struct packed {
		vec3_t       pos;
		vec3_t       vel;
		logic [63:0] sq;
		logic        over;
	} pei_item_t;

	typedef enum logic [2:0] {
		CL_IDLE,
		CL_SQRT,
		CL_MUL,
		CL_DIV,
		CL_DONE
	} cl_state_t;

	function automatic logic [31:0] sat32(input logic signed [63:0] x);
		logic [31:0] r;
		if (x > 64'sd2147483647) begin
			r = 32'h7fff_ffff;
		end else if (x < -64'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	// base + floor(prod / 2^shift), saturated
	function automatic logic [31:0] add_scaled(input logic [31:0] base,
	                                           input logic signed [52:0] prod,
	                                           input int unsigned shift);
		logic signed [63:0] b;
		logic signed [63:0] p;
		b = {{32{base[31]}}, base};
		p = {{11{prod[52]}}, prod};
		return sat32(b + (p >>> shift));
	endfunction

endpackage
`default_nettype wire

/* hdl/pei_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pei_front
// Accepts particles, applies acceleration and friction, squares the speed
// and marks items over the limit. Its stages never stall inside; in_stall
// holds off input, which it accepts only with room reserved in the queue.
// ----------------------------------------------------------------------------
module pei_front #(
	parameter int FRAC_BITS = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire pei_pkg::vec3_t  pos,
	input  wire pei_pkg::vec3_t  vel,
	input  wire pei_pkg::vec3_t  acc,
	input  wire [19:0]           time_step,
	input  wire [15:0]           friction,
	input  wire [30:0]           max_speed,
	input  wire [pei_pkg::QUEUE_AW:0] q_count,
	output logic                 push,
	output pei_pkg::pei_item_t   push_data
);

	logic v_s1, v_s2, v_s3, v_s4;
	pei_pkg::vec3_t pos_s1, vel_s1, acc_s1;
	pei_pkg::vec3_t pos_s2, vel_s2;
	pei_pkg::vec3_t pos_s3;
	pei_pkg::vec3_t pos_s4, v2_s4;
	logic [2:0][52:0] pa_s2;
	logic [2:0][49:0] pk_s3;
	logic [2:0][63:0] sq_s4;
	logic [61:0] ms2_q;
	logic [16:0] keep;
	logic [2:0] inflight;
	logic accept;
	logic [63:0] sum;

	assign inflight = 3'($countones({v_s1, v_s2, v_s3, v_s4}));
	assign in_stall = ({1'b0, q_count} + {2'b0, inflight}) >=
	                  5'(pei_pkg::QUEUE_DEPTH);
	assign accept   = in_valid && !in_stall;
	assign keep     = 17'h10000 - {1'b0, friction};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		ms2_q <= 62'(max_speed) * 62'(max_speed);
		if (accept) begin
			pos_s1 <= pos;
			vel_s1 <= vel;
			acc_s1 <= acc;
		end
		pos_s2 <= pos_s1;
		vel_s2 <= vel_s1;
		pos_s3 <= pos_s2;
		pos_s4 <= pos_s3;
		for (int i = 0; i < 3; i++) begin
			logic [31:0] v1;
			logic [31:0] v2;
			logic [31:0] m;
			pa_s2[i] <= 53'($signed({{21{acc_s1[i][31]}}, acc_s1[i]}) *
			                $signed({33'b0, time_step}));
			v1 = pei_pkg::add_scaled(vel_s2[i], $signed(pa_s2[i]), FRAC_BITS);
			pk_s3[i] <= 50'($signed({{18{v1[31]}}, v1}) * $signed({33'b0, keep}));
			v2 = 32'($signed(pk_s3[i]) >>> 16);
			m  = v2[31] ? 32'(-v2) : v2;
			v2_s4[i] <= v2;
			sq_s4[i] <= 64'(m) * 64'(m);
		end
	end

	assign sum = sq_s4[0] + sq_s4[1] + sq_s4[2];

	always_comb begin
		push           = v_s4;
		push_data.pos  = pos_s4;
		push_data.vel  = v2_s4;
		push_data.sq   = sum;
		push_data.over = sum > {2'b0, ms2_q};
	end

endmodule
`default_nettype wire

/* hdl/pei_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pei_queue
// Short first-in first-out queue between front and back.
// ----------------------------------------------------------------------------
module pei_queue (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      push,
	input  wire pei_pkg::pei_item_t  push_data,
	input  wire                      pop,
	output logic                     q_valid,
	output pei_pkg::pei_item_t       q_data,
	output logic [pei_pkg::QUEUE_AW:0] q_count
);

	pei_pkg::pei_item_t mem [pei_pkg::QUEUE_DEPTH];
	logic [pei_pkg::QUEUE_AW-1:0] wr_q, rd_q;
	logic [pei_pkg::QUEUE_AW:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= push_data;
	end

	assign q_valid = cnt_q != '0;
	assign q_data  = mem[rd_q];
	assign q_count = cnt_q;

endmodule
`default_nettype wire

/* hdl/pei_clamp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pei_clamp
// Speed limiter: bit-pair square root of the squared speed, then one
// restoring division per axis for |v| * max_speed / len.
// ----------------------------------------------------------------------------
module pei_clamp (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire                 ack,
	input  wire [63:0]          sq,
	input  wire pei_pkg::vec3_t vel,
	input  wire [30:0]          max_speed,
	output logic                idle,
	output logic                done,
	output pei_pkg::vec3_t      res
);

	pei_pkg::cl_state_t state_q, state_nxt;
	logic [4:0]  cnt_q;
	logic [1:0]  idx_q;
	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [31:0] drem_q;
	logic [30:0] nlo_q, quot_q;
	logic [2:0][31:0] mag_q;
	logic [2:0]  neg_q;
	logic [30:0] ms_q;
	pei_pkg::vec3_t res_q;
	logic do_sqrt, do_mul, do_div, last_sq, last_div;

	logic [35:0] srem;
	logic [35:0] trial;
	logic        sge;
	logic [62:0] prod;
	logic [32:0] drem2;
	logic        dge;
	logic [30:0] qn;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			pei_pkg::CL_IDLE: if (start)   state_nxt = pei_pkg::CL_SQRT;
			pei_pkg::CL_SQRT: if (last_sq) state_nxt = pei_pkg::CL_MUL;
			pei_pkg::CL_MUL:               state_nxt = pei_pkg::CL_DIV;
			pei_pkg::CL_DIV: begin
				if (last_div) state_nxt = (idx_q == 2'd2) ? pei_pkg::CL_DONE : pei_pkg::CL_MUL;
			end
			pei_pkg::CL_DONE: if (ack)     state_nxt = pei_pkg::CL_IDLE;
			default:                       state_nxt = pei_pkg::CL_IDLE;
		endcase
	end

	always_comb begin
		idle    = 1'b0;
		done    = 1'b0;
		do_sqrt = 1'b0;
		do_mul  = 1'b0;
		do_div  = 1'b0;
		case (state_q)
			pei_pkg::CL_IDLE: idle    = 1'b1;
			pei_pkg::CL_SQRT: do_sqrt = 1'b1;
			pei_pkg::CL_MUL:  do_mul  = 1'b1;
			pei_pkg::CL_DIV:  do_div  = 1'b1;
			pei_pkg::CL_DONE: done    = 1'b1;
			default:          idle    = 1'b0;
		endcase
	end

	assign last_sq  = cnt_q == 5'd31;
	assign last_div = cnt_q == 5'd30;

	assign srem  = {rem_q, rad_q[63:62]};
	assign trial = {2'b0, root_q, 2'b01};
	assign sge   = srem >= trial;
	assign prod  = 63'(mag_q[idx_q]) * 63'(ms_q);
	assign drem2 = {drem_q, nlo_q[30]};
	assign dge   = drem2 >= {1'b0, root_q};
	assign qn    = {quot_q[29:0], dge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pei_pkg::CL_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (idle && start) begin
			rad_q  <= sq;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			idx_q  <= '0;
			ms_q   <= max_speed;
			for (int i = 0; i < 3; i++) begin
				neg_q[i] <= vel[i][31];
				mag_q[i] <= vel[i][31] ? 32'(-vel[i]) : vel[i];
			end
		end
		if (do_sqrt) begin
			rad_q  <= {rad_q[61:0], 2'b00};
			rem_q  <= sge ? 34'(srem - trial) : srem[33:0];
			root_q <= {root_q[30:0], sge};
			cnt_q  <= last_sq ? 5'd0 : cnt_q + 5'd1;
		end
		if (do_mul) begin
			drem_q <= prod[62:31];
			nlo_q  <= prod[30:0];
			cnt_q  <= '0;
		end
		if (do_div) begin
			drem_q <= dge ? 32'(drem2 - {1'b0, root_q}) : drem2[31:0];
			nlo_q  <= {nlo_q[29:0], 1'b0};
			quot_q <= qn;
			cnt_q  <= cnt_q + 5'd1;
			if (last_div) begin
				res_q[idx_q] <= neg_q[idx_q] ? 32'(-{1'b0, qn}) : {1'b0, qn};
				idx_q        <= idx_q + 2'd1;
			end
		end
	end

	assign res = res_q;

endmodule
`default_nettype wire

/* hdl/pei_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pei_back
// Takes items from the queue, limits speed where marked, advances the
// position and holds the result for the output transfer.
// ----------------------------------------------------------------------------
module pei_back #(
	parameter int FRAC_BITS = 16
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     q_valid,
	input  wire pei_pkg::pei_item_t q_data,
	output logic                    pop,
	input  wire [19:0]              time_step,
	input  wire [30:0]              max_speed,
	output logic                    out_valid,
	input  wire                     out_stall,
	output pei_pkg::vec3_t          out_pos,
	output pei_pkg::vec3_t          out_vel,
	output logic                    out_clamped
);

	logic cl_idle, cl_done, cl_start, cl_ack;
	pei_pkg::vec3_t cl_res;

	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;
	pei_pkg::vec3_t pos_s1, vel_s1, pos_s2, vel_s2, pos_s3, vel_s3;
	logic [2:0][52:0] pd_s2;
	logic fl_s1, fl_s2, fl_s3;

	pei_clamp u_clamp (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cl_start),
		.ack       (cl_ack),
		.sq        (q_data.sq),
		.vel       (q_data.vel),
		.max_speed (max_speed),
		.idle      (cl_idle),
		.done      (cl_done),
		.res       (cl_res)
	);

	assign en_s3    = !v_s3 || !out_stall;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign pop      = q_valid && en_s1 && (!q_data.over || cl_done);
	assign cl_start = q_valid && q_data.over && cl_idle;
	assign cl_ack   = pop && q_data.over;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pop;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && pop) begin
			pos_s1 <= q_data.pos;
			vel_s1 <= q_data.over ? cl_res : q_data.vel;
			fl_s1  <= q_data.over;
		end
		if (en_s2) begin
			pos_s2 <= pos_s1;
			vel_s2 <= vel_s1;
			fl_s2  <= fl_s1;
			for (int i = 0; i < 3; i++) begin
				pd_s2[i] <= 53'($signed({{21{vel_s1[i][31]}}, vel_s1[i]}) *
				                $signed({33'b0, time_step}));
			end
		end
		if (en_s3) begin
			vel_s3 <= vel_s2;
			fl_s3  <= fl_s2;
			for (int i = 0; i < 3; i++) begin
				pos_s3[i] <= pei_pkg::add_scaled(pos_s2[i], $signed(pd_s2[i]), FRAC_BITS);
			end
		end
	end

	assign out_valid   = v_s3;
	assign out_pos     = pos_s3;
	assign out_vel     = vel_s3;
	assign out_clamped = fl_s3;

endmodule
`default_nettype wire

/* hdl/particle_euler_integrator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// particle_euler_integrator
// Semi-implicit Euler step for one particle per transfer, Q16.16 by default.
// ----------------------------------------------------------------------------
// One particle goes in and one result comes out per transfer, in order. The
// front pipeline takes a particle every cycle unless in_stall is high, and the
// result passes through four front stages, the queue write and three back
// stages before it is offered. A particle whose speed exceeds max_speed goes
// through a shared limiter: 32 square-root steps plus three divisions, during
// which later particles wait in the eight-entry queue. Unlimited particles
// sustain one per cycle while out_stall is low. Write configuration only
// while the block is empty.
module particle_euler_integrator #(
	parameter int FRAC_BITS = 16
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire [1:0]         cfg_index,
	input  wire [30:0]        cfg_data,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire signed [31:0] pos_x,
	input  wire signed [31:0] pos_y,
	input  wire signed [31:0] pos_z,
	input  wire signed [31:0] vel_x,
	input  wire signed [31:0] vel_y,
	input  wire signed [31:0] vel_z,
	input  wire signed [31:0] acc_x,
	input  wire signed [31:0] acc_y,
	input  wire signed [31:0] acc_z,
	output logic              out_valid,
	input  wire               out_stall,
	output logic signed [31:0] new_pos_x,
	output logic signed [31:0] new_pos_y,
	output logic signed [31:0] new_pos_z,
	output logic signed [31:0] new_vel_x,
	output logic signed [31:0] new_vel_y,
	output logic signed [31:0] new_vel_z,
	output logic              speed_clamped
);

	logic [19:0] time_step_q;
	logic [15:0] friction_q;
	logic [30:0] max_speed_q;

	logic push, pop, q_valid;
	pei_pkg::pei_item_t push_data, q_data;
	logic [pei_pkg::QUEUE_AW:0] q_count;
	pei_pkg::vec3_t out_pos, out_vel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= pei_pkg::TIME_STEP_RST;
			friction_q  <= pei_pkg::FRICTION_RST;
			max_speed_q <= pei_pkg::MAX_SPEED_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pei_pkg::REG_TIME_STEP: time_step_q <= cfg_data[19:0];
				pei_pkg::REG_FRICTION:  friction_q  <= cfg_data[15:0];
				pei_pkg::REG_MAX_SPEED: max_speed_q <= cfg_data;
				default:                ;
			endcase
		end
	end

	pei_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pos       ({pos_z, pos_y, pos_x}),
		.vel       ({vel_z, vel_y, vel_x}),
		.acc       ({acc_z, acc_y, acc_x}),
		.time_step (time_step_q),
		.friction  (friction_q),
		.max_speed (max_speed_q),
		.q_count   (q_count),
		.push      (push),
		.push_data (push_data)
	);

	pei_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_count   (q_count)
	);

	pei_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_data      (q_data),
		.pop         (pop),
		.time_step   (time_step_q),
		.max_speed   (max_speed_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_pos     (out_pos),
		.out_vel     (out_vel),
		.out_clamped (speed_clamped)
	);

	assign new_pos_x = $signed(out_pos[0]);
	assign new_pos_y = $signed(out_pos[1]);
	assign new_pos_z = $signed(out_pos[2]);
	assign new_vel_x = $signed(out_vel[0]);
	assign new_vel_y = $signed(out_vel[1]);
	assign new_vel_z = $signed(out_vel[2]);

endmodule
`default_nettype wire
